// ===== design/sts_pkg.sv =====
// sts_pkg: types, character constants and result codes for the script token scanner
// no dependencies; used by every file of the block
package sts_pkg;

    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_BITS = $clog2(RES_DEPTH);
    localparam int RES_PER_ITEM = 3;

    typedef logic [RES_PTR_BITS-1:0] ptr_t;
    typedef logic [RES_PTR_BITS:0] cnt_t;
    typedef logic [31:0] line_count_t;

    localparam logic [1:0] R_VALUE = 2'd0;
    localparam logic [1:0] R_DONE = 2'd1;
    localparam logic [1:0] R_ERROR = 2'd2;

    localparam logic [2:0] T_DIRECTIVE = 3'd0;
    localparam logic [2:0] T_STRING = 3'd1;
    localparam logic [2:0] T_SHELL = 3'd2;
    localparam logic [2:0] T_INTEGER = 3'd3;
    localparam logic [2:0] T_SYMBOL = 3'd4;
    localparam logic [2:0] T_ASSERT_END = 3'd5;

    localparam logic [2:0] E_NONE = 3'd0;
    localparam logic [2:0] E_UNEXPECTED = 3'd1;
    localparam logic [2:0] E_UNTERMINATED = 3'd2;
    localparam logic [2:0] E_EOF_ESCAPE = 3'd3;
    localparam logic [2:0] E_BAD_HEX = 3'd4;
    localparam logic [2:0] E_BAD_OCTAL = 3'd5;
    localparam logic [2:0] E_BAD_DECIMAL = 3'd6;
    localparam logic [2:0] E_BAD_SYMBOL = 3'd7;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_BACKTICK = 8'h60;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [2:0]  token_type;
        logic [7:0]  value_byte;
        logic [2:0]  error_code;
        line_count_t line_count;
        logic        last_of_run;
    } out_item_t;

    // up to three results written into the result queue at once
    typedef struct packed {
        logic                             write;
        logic [1:0]                       count;
        out_item_t [RES_PER_ITEM-1:0]     item;
    } push_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
    endfunction

    function automatic logic is_xdigit(input logic [7:0] c);
        return is_digit(c) || (c >= CH_LOWER_A && c <= CH_LOWER_F)
            || (c >= CH_UPPER_A && c <= CH_UPPER_F);
    endfunction

    function automatic out_item_t make_result(input logic [1:0] kind, input logic [2:0] ttype,
                                              input logic [7:0] b, input logic [2:0] err);
        out_item_t r;
        r = '0;
        r.result_kind = kind;
        r.token_type = ttype;
        r.value_byte = b;
        r.error_code = err;
        return r;
    endfunction

endpackage

// ===== design/sts_if.sv =====
// sts_if: valid/ready request channels for the script token scanner
// depends on sts_pkg for the payload types
interface sts_in_if;
    logic              valid;
    logic              ready;
    sts_pkg::in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sts_out_if;
    logic               valid;
    logic               ready;
    sts_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== design/script_token_scanner.sv =====
// script_token_scanner: top level of the streaming script tokenizer
// depends on sts_pkg, sts_if, sts_scanner and sts_result_fifo
//
// One character or end-of-stream request is taken per clock unless the input stalls. A
// request passes an input register, is decoded by the scanner state machine, and its zero
// to three results go into a four-entry result queue that drives the output channel one
// result per cycle while the output is ready; the first result is offered once the
// request has passed the input register and been written into the queue. Input throughput
// is one request per cycle while each request yields at most one result and the output is
// taken every cycle; a request with two or three results puts them out in turn,
// and the input stalls only when the queue lacks room for the results of the held request.
module script_token_scanner #(
    parameter int LINE_COUNT_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    sts_in_if.sink     in_chan,
    sts_out_if.source  out_chan
);

    logic              in_valid_reg;
    sts_pkg::in_item_t in_item_reg;
    logic              advance;
    sts_pkg::cnt_t     room;
    sts_pkg::push_t    push;

    assign in_chan.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_chan.ready)
        begin
            in_valid_reg <= in_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_chan.ready && in_chan.valid)
        begin
            in_item_reg <= in_chan.payload;
        end
    end

    sts_scanner #(
        .LINE_COUNT_BITS (LINE_COUNT_BITS)
    ) u_scanner (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item       (in_item_reg),
        .room       (room),
        .advance    (advance),
        .push       (push)
    );

    sts_result_fifo u_result_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (room),
        .out_chan (out_chan)
    );

endmodule

// ===== design/sts_scanner.sv =====
// sts_scanner: per-character tokenizer state machine and line counter
// depends on sts_pkg; produces up to three results per request for sts_result_fifo
module sts_scanner #(
    parameter int LINE_COUNT_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  sts_pkg::in_item_t item,
    input  sts_pkg::cnt_t     room,
    output logic              advance,
    output sts_pkg::push_t    push
);

    typedef enum logic [3:0] {
        M_IDLE,
        M_COMMENT,
        M_DIRECTIVE,
        M_STR,
        M_STR_ESC,
        M_STR_AFTER,
        M_OCT_FIRST,
        M_OCT_REST,
        M_DEC,
        M_SYM
    } mode_t;

    mode_t                      mode_reg, mode_next;
    logic [2:0]                 type_reg, type_next;
    logic [7:0]                 delim_reg, delim_next;
    logic                       hex_reg, hex_next;
    logic                       drain_reg, drain_next;
    logic [LINE_COUNT_BITS-1:0] line_reg, line_next;

    sts_pkg::out_item_t [sts_pkg::RES_PER_ITEM-1:0] items;
    logic [1:0]                 n;
    logic                       restart;
    logic [7:0]                 c;
    logic                       ws;

    assign c = item.char_byte;
    assign ws = sts_pkg::is_ws(c);

    always_comb
    begin
        mode_next = mode_reg;
        type_next = type_reg;
        delim_next = delim_reg;
        hex_next = hex_reg;
        drain_next = drain_reg;
        line_next = line_reg;
        items = '0;
        n = 2'd0;
        restart = 1'b0;

        if (item.kind)
        begin
            // end of stream closes whatever is pending
            unique case (mode_reg)
                M_DIRECTIVE, M_STR_AFTER, M_OCT_FIRST, M_OCT_REST, M_DEC, M_SYM:
                begin
                    items[n] = sts_pkg::make_result(sts_pkg::R_DONE, type_reg, 8'd0,
                                                    sts_pkg::E_NONE);
                    n = n + 2'd1;
                end
                M_STR:
                begin
                    items[n] = sts_pkg::make_result(sts_pkg::R_ERROR, type_reg, 8'd0,
                                                    sts_pkg::E_UNTERMINATED);
                    n = n + 2'd1;
                end
                M_STR_ESC:
                begin
                    items[n] = sts_pkg::make_result(sts_pkg::R_ERROR, type_reg, 8'd0,
                                                    sts_pkg::E_EOF_ESCAPE);
                    n = n + 2'd1;
                end
                default:
                begin
                end
            endcase
            mode_next = M_IDLE;
            hex_next = 1'b0;
            drain_next = 1'b0;
        end
        else
        begin
            if (c == sts_pkg::CH_LF)
            begin
                line_next = line_reg + LINE_COUNT_BITS'(1);
            end
            if (drain_reg)
            begin
                if (ws)
                begin
                    drain_next = 1'b0;
                    mode_next = M_IDLE;
                end
            end
            else
            begin
                unique case (mode_reg)
                    M_COMMENT:
                    begin
                        if (c == sts_pkg::CH_LF)
                        begin
                            mode_next = M_IDLE;
                        end
                    end
                    M_DIRECTIVE:
                    begin
                        if (c == sts_pkg::CH_DOT || c == sts_pkg::CH_DASH
                            || c == sts_pkg::CH_UNDERSCORE || sts_pkg::is_alpha(c)
                            || sts_pkg::is_digit(c))
                        begin
                            items[n] = sts_pkg::make_result(sts_pkg::R_VALUE, type_next, c,
                                                            sts_pkg::E_NONE);
                            n = n + 2'd1;
                        end
                        else
                        begin
                            items[n] = sts_pkg::make_result(sts_pkg::R_DONE, type_next, 8'd0,
                                                            sts_pkg::E_NONE);
                            n = n + 2'd1;
                            restart = 1'b1;
                        end
                    end
                    M_STR:
                    begin
                        if (c == delim_reg)
                        begin
                            if (c == sts_pkg::CH_SQUOTE)
                            begin
                                items[n] = sts_pkg::make_result(sts_pkg::R_DONE, type_next,
                                                                8'd0, sts_pkg::E_NONE);
                                n = n + 2'd1;
                                mode_next = M_IDLE;
                            end
                            else
                            begin
                                mode_next = M_STR_AFTER;
                            end
                        end
                        else if (c == sts_pkg::CH_BSLASH)
                        begin
                            mode_next = M_STR_ESC;
                        end
                        else
                        begin
                            items[n] = sts_pkg::make_result(sts_pkg::R_VALUE, type_next, c,
                                                            sts_pkg::E_NONE);
                            n = n + 2'd1;
                        end
                    end
                    M_STR_ESC:
                    begin
                        items[n] = sts_pkg::make_result(sts_pkg::R_VALUE, type_next, c,
                                                        sts_pkg::E_NONE);
                        n = n + 2'd1;
                        mode_next = M_STR;
                    end
                    M_STR_AFTER:
                    begin
                        // adjacent strings join into one token
                        if (!ws)
                        begin
                            if (c == delim_reg)
                            begin
                                mode_next = M_STR;
                            end
                            else
                            begin
                                items[n] = sts_pkg::make_result(sts_pkg::R_DONE, type_next,
                                                                8'd0, sts_pkg::E_NONE);
                                n = n + 2'd1;
                                restart = 1'b1;
                            end
                        end
                    end
                    M_OCT_FIRST:
                    begin
                        if (ws)
                        begin
                            items[n] = sts_pkg::make_result(sts_pkg::R_DONE, type_next, 8'd0,
                                                            sts_pkg::E_NONE);
                            n = n + 2'd1;
                            mode_next = M_IDLE;
                        end
                        else
                        begin
                            if (c == sts_pkg::CH_LOWER_X || c == sts_pkg::CH_UPPER_X)
                            begin
                                hex_next = 1'b1;
                            end
                            items[n] = sts_pkg::make_result(sts_pkg::R_VALUE, type_next, c,
                                                            sts_pkg::E_NONE);
                            n = n + 2'd1;
                            mode_next = M_OCT_REST;
                        end
                    end
                    M_OCT_REST:
                    begin
                        if (ws)
                        begin
                            items[n] = sts_pkg::make_result(sts_pkg::R_DONE, type_next, 8'd0,
                                                            sts_pkg::E_NONE);
                            n = n + 2'd1;
                            mode_next = M_IDLE;
                        end
                        else if (hex_reg ? sts_pkg::is_xdigit(c)
                                         : (c >= sts_pkg::CH_ZERO && c <= sts_pkg::CH_SEVEN))
                        begin
                            items[n] = sts_pkg::make_result(sts_pkg::R_VALUE, type_next, c,
                                                            sts_pkg::E_NONE);
                            n = n + 2'd1;
                        end
                        else
                        begin
                            items[n] = sts_pkg::make_result(sts_pkg::R_ERROR, type_next, c,
                                hex_reg ? sts_pkg::E_BAD_HEX : sts_pkg::E_BAD_OCTAL);
                            n = n + 2'd1;
                            mode_next = M_IDLE;
                            drain_next = 1'b1;
                        end
                    end
                    M_DEC, M_SYM:
                    begin
                        if (ws)
                        begin
                            items[n] = sts_pkg::make_result(sts_pkg::R_DONE, type_next, 8'd0,
                                                            sts_pkg::E_NONE);
                            n = n + 2'd1;
                            mode_next = M_IDLE;
                        end
                        else if (sts_pkg::is_digit(c) || (mode_reg == M_SYM
                                 && (sts_pkg::is_alpha(c) || c == sts_pkg::CH_UNDERSCORE)))
                        begin
                            items[n] = sts_pkg::make_result(sts_pkg::R_VALUE, type_next, c,
                                                            sts_pkg::E_NONE);
                            n = n + 2'd1;
                        end
                        else
                        begin
                            items[n] = sts_pkg::make_result(sts_pkg::R_ERROR, type_next, c,
                                (mode_reg == M_SYM) ? sts_pkg::E_BAD_SYMBOL
                                                    : sts_pkg::E_BAD_DECIMAL);
                            n = n + 2'd1;
                            mode_next = M_IDLE;
                            drain_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        restart = 1'b1;
                    end
                endcase

                // start of a new token
                if (restart)
                begin
                    mode_next = M_IDLE;
                    if (ws)
                    begin
                    end
                    else if (c == sts_pkg::CH_HASH)
                    begin
                        mode_next = M_COMMENT;
                    end
                    else if (c == sts_pkg::CH_SEMI)
                    begin
                        type_next = sts_pkg::T_ASSERT_END;
                        items[n] = sts_pkg::make_result(sts_pkg::R_VALUE, type_next, c,
                                                        sts_pkg::E_NONE);
                        n = n + 2'd1;
                        items[n] = sts_pkg::make_result(sts_pkg::R_DONE, type_next, 8'd0,
                                                        sts_pkg::E_NONE);
                        n = n + 2'd1;
                    end
                    else if (c == sts_pkg::CH_DOT)
                    begin
                        type_next = sts_pkg::T_DIRECTIVE;
                        items[n] = sts_pkg::make_result(sts_pkg::R_VALUE, type_next, c,
                                                        sts_pkg::E_NONE);
                        n = n + 2'd1;
                        mode_next = M_DIRECTIVE;
                    end
                    else if (c == sts_pkg::CH_SQUOTE || c == sts_pkg::CH_DQUOTE
                             || c == sts_pkg::CH_BACKTICK)
                    begin
                        type_next = (c == sts_pkg::CH_BACKTICK) ? sts_pkg::T_SHELL
                                                                : sts_pkg::T_STRING;
                        delim_next = c;
                        mode_next = M_STR;
                    end
                    else if (c == sts_pkg::CH_ZERO)
                    begin
                        type_next = sts_pkg::T_INTEGER;
                        hex_next = 1'b0;
                        items[n] = sts_pkg::make_result(sts_pkg::R_VALUE, type_next, c,
                                                        sts_pkg::E_NONE);
                        n = n + 2'd1;
                        mode_next = M_OCT_FIRST;
                    end
                    else if (sts_pkg::is_digit(c))
                    begin
                        type_next = sts_pkg::T_INTEGER;
                        items[n] = sts_pkg::make_result(sts_pkg::R_VALUE, type_next, c,
                                                        sts_pkg::E_NONE);
                        n = n + 2'd1;
                        mode_next = M_DEC;
                    end
                    else if (sts_pkg::is_alpha(c) || c == sts_pkg::CH_UNDERSCORE)
                    begin
                        type_next = sts_pkg::T_SYMBOL;
                        items[n] = sts_pkg::make_result(sts_pkg::R_VALUE, type_next, c,
                                                        sts_pkg::E_NONE);
                        n = n + 2'd1;
                        mode_next = M_SYM;
                    end
                    else
                    begin
                        type_next = sts_pkg::T_DIRECTIVE;
                        items[n] = sts_pkg::make_result(sts_pkg::R_ERROR, type_next, c,
                                                        sts_pkg::E_UNEXPECTED);
                        n = n + 2'd1;
                        drain_next = 1'b1;
                    end
                end
            end
        end

        for (int k = 0; k < sts_pkg::RES_PER_ITEM; k++)
        begin
            items[k].line_count = sts_pkg::line_count_t'(line_next);
            items[k].last_of_run = (2'(k + 1) == n);
        end
    end

    assign advance = item_valid && ({1'b0, n} <= room);
    assign push.write = advance;
    assign push.count = n;
    assign push.item = items;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            type_reg <= '0;
            delim_reg <= '0;
            hex_reg <= 1'b0;
            drain_reg <= 1'b0;
            line_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            type_reg <= type_next;
            delim_reg <= delim_next;
            hex_reg <= hex_next;
            drain_reg <= drain_next;
            line_reg <= line_next;
        end
    end

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg |-> mode_reg == M_IDLE)
        else $error("drop-after-error flag set outside idle mode");

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item.kind) |=> (mode_reg == M_IDLE && !drain_reg))
        else $error("end of stream did not return scanner to idle");
`endif

endmodule

// ===== design/sts_result_fifo.sv =====
// sts_result_fifo: small result queue taking up to three results per cycle
// depends on sts_pkg and sts_if; feeds the output channel one result per cycle while it is ready
module sts_result_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  sts_pkg::push_t     push,
    output sts_pkg::cnt_t      room,
    sts_out_if.source          out_chan
);

    sts_pkg::out_item_t             mem_reg [sts_pkg::RES_DEPTH];
    sts_pkg::ptr_t                  wr_ptr_reg, wr_ptr_next;
    sts_pkg::ptr_t                  rd_ptr_reg, rd_ptr_next;
    sts_pkg::cnt_t                  count_reg, count_next;
    logic                           pop;
    sts_pkg::cnt_t                  push_count;

    assign push_count = push.write ? sts_pkg::cnt_t'(push.count) : '0;
    assign pop = out_chan.valid && out_chan.ready;
    assign room = sts_pkg::cnt_t'(sts_pkg::RES_DEPTH) - count_reg;

    assign out_chan.valid = (count_reg != '0);
    assign out_chan.payload = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + sts_pkg::ptr_t'(push_count);
    assign rd_ptr_next = rd_ptr_reg + sts_pkg::ptr_t'(pop);
    assign count_next = count_reg + push_count - sts_pkg::cnt_t'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < sts_pkg::RES_PER_ITEM; k++)
        begin
            if (push.write && (2'(k) < push.count))
            begin
                mem_reg[wr_ptr_reg + sts_pkg::ptr_t'(k)] <= push.item[k];
            end
        end
    end

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sts_pkg::cnt_t'(sts_pkg::RES_DEPTH))
        else $error("result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push_count == '0) |=> count_reg == $past(count_reg) - sts_pkg::cnt_t'(1))
        else $error("result queue count lost a pop");
`endif

endmodule
